// ----- src/i2a_pkg.sv -----
// i2a_pkg: constants and the digit glyph function for the integer to ascii converter
// no dependencies; used by integer_to_ascii_radix_converter_top
package i2a_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_UPPER = 8'h41;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // uppercase glyph for one digit 0..15
  function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
    logic [7:0] ch;
    if (digit < 4'd10) begin
      ch = ASCII_ZERO + {4'd0, digit};
    end else begin
      ch = ASCII_UPPER + {4'd0, digit} - 8'd10;
    end
    return ch;
  endfunction

endpackage

// ----- src/integer_to_ascii_radix_converter_top.sv -----
// integer to ascii converter: bit-serial restoring divider, digit stack and emit sequencer
// timing: zero or a bad radix gives a single '0' beat the cycle after start (busy stays low); for
// other values the sign beat, if any, is registered as the last digit is pushed, then the digits follow
// busy stays high through division and emission, sign or not; the divider retires one quotient bit
// per cycle, and a new start is taken only while busy is low
// reset: asynchronous, clears the sequencer and the strobe; results cannot be stalled
module integer_to_ascii_radix_converter_top #(
  parameter int unsigned VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [VALUE_WIDTH-1:0] value_bits_i,
  input  logic                   signed_mode_i,
  input  logic [4:0]             radix_i,
  output logic                   valid_o,
  output logic [7:0]             text_char_o,
  output logic                   last_char_o
);

  localparam int unsigned BitCntW = $clog2(VALUE_WIDTH);
  localparam int unsigned DigCntW = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e               state_q;
  logic [VALUE_WIDTH-1:0] dvd_q;
  logic [3:0]           rem_q;
  logic [4:0]           radix_q;
  logic                 neg_q;
  logic [BitCntW-1:0]   bit_cnt_q;
  logic [DigCntW-1:0]   dig_cnt_q;
  logic [3:0]           stk_q [VALUE_WIDTH];
  logic                 valid_q;
  logic [7:0]           char_q;
  logic                 last_q;

  logic                   accept;
  logic                   radix_ok;
  logic                   is_neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [4:0]             r_sh;
  logic                   q_bit;
  logic [3:0]             rem_d;
  logic [VALUE_WIDTH-1:0] dvd_d;
  logic                   digit_done;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign radix_ok = radix_i inside {[i2a_pkg::RADIX_MIN:i2a_pkg::RADIX_MAX]};
  assign is_neg   = signed_mode_i && value_bits_i[VALUE_WIDTH-1];
  assign mag      = is_neg ? (~value_bits_i + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_bits_i;

  // one restoring division step
  assign r_sh       = {rem_q, dvd_q[VALUE_WIDTH-1]};
  assign q_bit      = (r_sh >= radix_q);
  assign rem_d      = q_bit ? 4'(r_sh - radix_q) : r_sh[3:0];
  assign dvd_d      = {dvd_q[VALUE_WIDTH-2:0], q_bit};
  assign digit_done = (bit_cnt_q == BitCntW'(VALUE_WIDTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= 1'b0;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!radix_ok || (value_bits_i == '0)) begin
              valid_q <= 1'b1;
              char_q  <= i2a_pkg::ASCII_ZERO;
              last_q  <= 1'b1;
            end else begin
              dvd_q     <= mag;
              rem_q     <= 4'd0;
              radix_q   <= radix_i;
              neg_q     <= is_neg;
              bit_cnt_q <= '0;
              dig_cnt_q <= '0;
              state_q   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          dvd_q <= dvd_d;
          if (digit_done) begin
            // push the finished digit onto the stack
            stk_q[0] <= rem_d;
            for (int i = 1; i < VALUE_WIDTH; i++) begin
              stk_q[i] <= stk_q[i-1];
            end
            dig_cnt_q <= dig_cnt_q + DigCntW'(1);
            rem_q     <= 4'd0;
            bit_cnt_q <= '0;
            if (dvd_d == '0) begin
              state_q <= ST_EMIT;
              if (neg_q) begin
                valid_q <= 1'b1;
                char_q  <= i2a_pkg::ASCII_MINUS;
                last_q  <= 1'b0;
              end
            end
          end else begin
            rem_q     <= rem_d;
            bit_cnt_q <= bit_cnt_q + BitCntW'(1);
          end
        end
        ST_EMIT: begin
          // pop most significant digit, one beat per cycle
          valid_q <= 1'b1;
          char_q  <= i2a_pkg::digit_glyph(stk_q[0]);
          last_q  <= (dig_cnt_q == DigCntW'(1));
          for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
            stk_q[i] <= stk_q[i+1];
          end
          dig_cnt_q <= dig_cnt_q - DigCntW'(1);
          if (dig_cnt_q == DigCntW'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign valid_o     = valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule
